// ===== rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shared concurrent assertion macros for the header builder checkers.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while rst_sig is high
`define CHK_IMPLIES(lbl, clk_sig, rst_sig, ante, cons) \
  lbl: assert property (@(posedge clk_sig) disable iff (rst_sig) (ante) |-> (cons)) \
    else $error("same-cycle check failed");

// next-cycle implication, disabled while rst_sig is high
`define CHK_NEXT(lbl, clk_sig, rst_sig, ante, cons) \
  lbl: assert property (@(posedge clk_sig) disable iff (rst_sig) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

// ===== rtl/ithb_pkg.sv =====
// ----------------------------------------------------------------------------
// ithb_pkg
// Types, constants and word/checksum helpers of the IPv4+TCP SYN header builder.
// ----------------------------------------------------------------------------
package ithb_pkg;

  localparam int HDR_WORDS  = 10;
  localparam int WORD_IDX_W = 4;
  localparam int SUM_W      = 20;

  localparam logic [WORD_IDX_W-1:0] WORD_IP_VER   = 4'd0;
  localparam logic [WORD_IDX_W-1:0] WORD_IP_ID    = 4'd1;
  localparam logic [WORD_IDX_W-1:0] WORD_IP_TTL   = 4'd2;
  localparam logic [WORD_IDX_W-1:0] WORD_IP_SRC   = 4'd3;
  localparam logic [WORD_IDX_W-1:0] WORD_IP_DST   = 4'd4;
  localparam logic [WORD_IDX_W-1:0] WORD_TCP_PORT = 4'd5;
  localparam logic [WORD_IDX_W-1:0] WORD_TCP_SEQ  = 4'd6;
  localparam logic [WORD_IDX_W-1:0] WORD_TCP_ACK  = 4'd7;
  localparam logic [WORD_IDX_W-1:0] WORD_TCP_WND  = 4'd8;
  localparam logic [WORD_IDX_W-1:0] WORD_TCP_CSUM = 4'd9;
  localparam logic [WORD_IDX_W-1:0] WORD_LAST     = WORD_TCP_CSUM;

  localparam logic STATUS_OK     = 1'b0;
  localparam logic STATUS_REJECT = 1'b1;

  localparam logic [7:0]  TTL_RESET     = 8'd64;
  localparam logic [7:0]  IP_VER_IHL    = 8'((4 << 4) | 5);
  localparam logic [7:0]  IP_TOS        = 8'h00;
  localparam logic [15:0] IP_TOTAL_LEN  = 16'd40;
  localparam logic [15:0] IP_FLAGS_DF   = 16'h4000;
  localparam logic [7:0]  PROTO_NUM_TCP = 8'd6;
  localparam logic [15:0] TCP_LEN       = 16'd20;
  localparam logic [15:0] TCP_OFF_FLAGS = 16'h5002;
  localparam logic [15:0] CSUM_ZERO_SUB = 16'hffff;

  // fixed parts of both sums
  localparam logic [SUM_W-1:0] IP_SUM_CONST =
    SUM_W'({IP_VER_IHL, IP_TOS}) + SUM_W'(IP_TOTAL_LEN) + SUM_W'(IP_FLAGS_DF)
    + SUM_W'(PROTO_NUM_TCP);
  localparam logic [SUM_W-1:0] TCP_SUM_CONST =
    SUM_W'(PROTO_NUM_TCP) + SUM_W'(TCP_LEN) + SUM_W'(TCP_OFF_FLAGS);

  // input fields, first field in the highest bits
  typedef struct packed {
    logic [15:0] ip_ident;
    logic [31:0] seq_number;
    logic [31:0] ack_number;
    logic [15:0] window;
    logic [15:0] src_port;
    logic [15:0] dest_port;
    logic [31:0] src_addr;
    logic [31:0] dest_addr;
  } hdr_fields_t;

  // one queued header job
  typedef struct packed {
    hdr_fields_t f;
    logic [7:0]  ttl;
    logic [15:0] ip_csum;
    logic [15:0] tcp_csum;
    logic        reject;
  } hdr_job_t;

  // end-around carry fold, complement, zero sent as all ones
  function automatic logic [15:0] csum_finish(input logic [SUM_W-1:0] acc);
    logic [16:0] f1;
    logic [16:0] f2;
    logic [15:0] r;
    f1 = 17'(acc[15:0]) + 17'(acc[SUM_W-1:16]);
    f2 = 17'(f1[15:0]) + 17'(f1[16]);
    r  = ~f2[15:0];
    return (r == 16'h0000) ? CSUM_ZERO_SUB : r;
  endfunction

  // header word by index
  function automatic logic [31:0] hdr_word(input hdr_job_t j,
                                           input logic [WORD_IDX_W-1:0] idx);
    logic [31:0] w;
    case (idx)
      WORD_IP_VER:   w = {IP_VER_IHL, IP_TOS, IP_TOTAL_LEN};
      WORD_IP_ID:    w = {j.f.ip_ident, IP_FLAGS_DF};
      WORD_IP_TTL:   w = {j.ttl, PROTO_NUM_TCP, j.ip_csum};
      WORD_IP_SRC:   w = j.f.src_addr;
      WORD_IP_DST:   w = j.f.dest_addr;
      WORD_TCP_PORT: w = {j.f.src_port, j.f.dest_port};
      WORD_TCP_SEQ:  w = j.f.seq_number;
      WORD_TCP_ACK:  w = j.f.ack_number;
      WORD_TCP_WND:  w = {TCP_OFF_FLAGS, j.f.window};
      WORD_TCP_CSUM: w = {j.tcp_csum, 16'h0000};
      default:       w = 32'h0;
    endcase
    return w;
  endfunction

endpackage

// ===== rtl/ithb_front.sv =====
// ----------------------------------------------------------------------------
// ithb_front
// Accepts requests, classifies them and computes both checksums in two stages.
// ----------------------------------------------------------------------------
module ithb_front (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_wr_en,
  input  logic [7:0]         cfg_wr_data,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [191:0]       in_data,
  input  logic [1:0]         in_user,
  output logic               push,
  input  logic               full,
  output ithb_pkg::hdr_job_t push_job
);
  import ithb_pkg::*;

  logic [7:0]  ttl;

  logic        s1_valid;
  hdr_fields_t s1_f;
  logic        s1_reject;

  logic        s2_valid;
  hdr_fields_t s2_f;
  logic        s2_reject;
  logic [7:0]  s2_ttl;
  logic [SUM_W-1:0] s2_ip_sum;
  logic [SUM_W-1:0] s2_tcp_sum;

  logic        s2_free;
  logic        s1_move;
  logic        in_fire;
  logic [SUM_W-1:0] ip_sum;
  logic [SUM_W-1:0] tcp_sum;

  // handshake between stages
  assign s2_free  = !s2_valid || !full;
  assign s1_move  = s1_valid && s2_free;
  assign in_ready = !s1_valid || s2_free;
  assign in_fire  = in_valid && in_ready;
  assign push     = s2_valid && !full;

  // raw 20-bit sums of the 16-bit words before folding
  always_comb begin
    ip_sum = IP_SUM_CONST + SUM_W'(s1_f.ip_ident)
           + SUM_W'({ttl, 8'h00})
           + SUM_W'(s1_f.src_addr[31:16]) + SUM_W'(s1_f.src_addr[15:0])
           + SUM_W'(s1_f.dest_addr[31:16]) + SUM_W'(s1_f.dest_addr[15:0]);
    tcp_sum = TCP_SUM_CONST
            + SUM_W'(s1_f.src_addr[31:16]) + SUM_W'(s1_f.src_addr[15:0])
            + SUM_W'(s1_f.dest_addr[31:16]) + SUM_W'(s1_f.dest_addr[15:0])
            + SUM_W'(s1_f.src_port) + SUM_W'(s1_f.dest_port)
            + SUM_W'(s1_f.seq_number[31:16]) + SUM_W'(s1_f.seq_number[15:0])
            + SUM_W'(s1_f.ack_number[31:16]) + SUM_W'(s1_f.ack_number[15:0])
            + SUM_W'(s1_f.window);
  end

  // ttl register and stage valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      ttl      <= TTL_RESET;
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        ttl <= cfg_wr_data;
      end
      if (in_ready) begin
        s1_valid <= in_valid;
      end
      if (s2_free) begin
        s2_valid <= s1_valid;
      end
    end
  end

  // stage payloads
  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_f      <= hdr_fields_t'(in_data);
      s1_reject <= !(in_user[0] && in_user[1]);
    end
    if (s1_move) begin
      s2_f       <= s1_f;
      s2_reject  <= s1_reject;
      s2_ttl     <= ttl;
      s2_ip_sum  <= ip_sum;
      s2_tcp_sum <= tcp_sum;
    end
  end

  // fold and complement into the queued job
  always_comb begin
    push_job.f        = s2_f;
    push_job.ttl      = s2_ttl;
    push_job.ip_csum  = csum_finish(s2_ip_sum);
    push_job.tcp_csum = csum_finish(s2_tcp_sum);
    push_job.reject   = s2_reject;
  end

endmodule

// ===== rtl/ithb_queue.sv =====
// ----------------------------------------------------------------------------
// ithb_queue
// Short first-in first-out queue of header jobs between front and back.
// ----------------------------------------------------------------------------
module ithb_queue #(
  parameter int DEPTH = 2
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  ithb_pkg::hdr_job_t push_job,
  output logic               full,
  input  logic               pop,
  output logic               empty,
  output ithb_pkg::hdr_job_t head_job
);
  import ithb_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_MAX = PTR_W'(DEPTH - 1);

  hdr_job_t          slots [DEPTH];
  logic [PTR_W-1:0]  wr_ptr;
  logic [PTR_W-1:0]  rd_ptr;
  logic [CNT_W-1:0]  count;
  logic              do_push;
  logic              do_pop;

  assign full     = (count == CNT_W'(DEPTH));
  assign empty    = (count == '0);
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign head_job = slots[rd_ptr];

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_MAX) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_MAX) ? '0 : rd_ptr + 1'b1;
      end
      case ({do_push, do_pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  // slot storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_job;
    end
  end

endmodule

// ===== rtl/ithb_back.sv =====
// ----------------------------------------------------------------------------
// ithb_back
// Walks the queued job word by word into the registered output stage.
// ----------------------------------------------------------------------------
module ithb_back (
  input  logic               clk,
  input  logic               rst,
  input  logic               empty,
  input  ithb_pkg::hdr_job_t head_job,
  output logic               pop,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [31:0]        out_data,
  output logic               out_last,
  output logic               out_user
);
  import ithb_pkg::*;

  logic [WORD_IDX_W-1:0] widx;
  logic                  load;
  logic                  job_done;

  assign load     = !empty && (!out_valid || out_ready);
  assign job_done = head_job.reject || (widx == WORD_LAST);
  assign pop      = load && job_done;

  // word counter and output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      widx      <= '0;
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
      widx      <= job_done ? '0 : widx + 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // output payload
  always_ff @(posedge clk) begin
    if (load) begin
      out_data <= head_job.reject ? 32'h0 : hdr_word(head_job, widx);
      out_last <= job_done;
      out_user <= head_job.reject ? STATUS_REJECT : STATUS_OK;
    end
  end

endmodule

// ===== rtl/ipv4_tcp_syn_header_builder.sv =====
// ----------------------------------------------------------------------------
// ipv4_tcp_syn_header_builder
// Builds a 40-byte IPv4+TCP SYN header as ten 32-bit words per request, or one reject word.
// ----------------------------------------------------------------------------
// channel   dir  handshake                     payload
// s_axis    in   s_axis_tvalid/s_axis_tready   tdata 192b fields, tuser 2b v4 flags
// m_axis    out  m_axis_tvalid/m_axis_tready   tdata header word, tlast, tuser status
// cfg       in   cfg_wr_en                     cfg_wr_data ttl byte
//
// each accepted IPv4 request yields ten output words, one per cycle while
// m_axis_tready is high; a rejected one yields one word, so the word walker
// in the back end sets the rate
// after acceptance the first word passes: second front stage, queue, output register
// a new request is taken while earlier ones are still being sent
// rst clears all valid bits and the queue and sets ttl to 64
// backpressure on m_axis fills the queue and then drops s_axis_tready
// ----------------------------------------------------------------------------
module ipv4_tcp_syn_header_builder #(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         cfg_wr_en,
  input  logic [7:0]   cfg_wr_data,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // dest_addr, src_addr, dest_port, src_port, window, ack_number, seq_number,
  // ip_ident
  input  logic [191:0] s_axis_tdata,
  // dest_is_ipv4, src_is_ipv4
  input  logic [1:0]   s_axis_tuser,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // header_word
  output logic [31:0]  m_axis_tdata,
  output logic         m_axis_tlast,
  // status
  output logic         m_axis_tuser
);
  import ithb_pkg::*;

  logic     q_push;
  logic     q_full;
  logic     q_pop;
  logic     q_empty;
  hdr_job_t q_in_job;
  hdr_job_t q_head_job;

  // request intake and checksums
  ithb_front u_front (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_valid    (s_axis_tvalid),
    .in_ready    (s_axis_tready),
    .in_data     (s_axis_tdata),
    .in_user     (s_axis_tuser),
    .push        (q_push),
    .full        (q_full),
    .push_job    (q_in_job)
  );

  // job queue
  ithb_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (q_push),
    .push_job (q_in_job),
    .full     (q_full),
    .pop      (q_pop),
    .empty    (q_empty),
    .head_job (q_head_job)
  );

  // word emission
  ithb_back u_back (
    .clk       (clk),
    .rst       (rst),
    .empty     (q_empty),
    .head_job  (q_head_job),
    .pop       (q_pop),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_data  (m_axis_tdata),
    .out_last  (m_axis_tlast),
    .out_user  (m_axis_tuser)
  );

endmodule

// ===== rtl/ithb_checker.sv =====
// ----------------------------------------------------------------------------
// ithb_checker
// Port-level checks on the header builder output stream.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module ithb_checker (
  input logic        clk,
  input logic        rst,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [31:0] m_axis_tdata,
  input logic        m_axis_tlast,
  input logic        m_axis_tuser
);
  import ithb_pkg::*;

  logic reject_item;
  logic out_stall;

  // rejected item on the output and a stalled output item
  assign reject_item = m_axis_tvalid && (m_axis_tuser == STATUS_REJECT);
  assign out_stall   = m_axis_tvalid && !m_axis_tready;

  // a rejection is always a single closing item
  `CHK_IMPLIES(a_reject_last, clk, rst, reject_item, m_axis_tlast)

  // a rejection carries an all-zero word
  `CHK_IMPLIES(a_reject_zero, clk, rst, reject_item, m_axis_tdata == 32'h0)

  // a stalled item holds
  `CHK_NEXT(a_stall_hold, clk, rst, out_stall, m_axis_tvalid && $stable(m_axis_tdata))

  // output is empty right after reset
  `CHK_NEXT(a_reset_idle, clk, 1'b0, rst, !m_axis_tvalid)

endmodule

bind ipv4_tcp_syn_header_builder ithb_checker u_ithb_checker (.*);

// ===== test/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the IPv4+TCP SYN header builder: drives header
// requests on the input stream, predicts all ten header words (or the single
// reject word) for each accepted request, and compares every output word in
// order under random stalls, a long output hold-off and several TTL values.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import ithb_pkg::*;

  // tuser value with both endpoints IPv4 (bit 0 dest, bit 1 src)
  localparam logic [1:0] BOTH_V4 = 2'b11;

  // one output item: header word with its end and status flags
  typedef struct packed {
    logic [31:0] word;
    logic        last;
    logic        status;
  } header_word_t;

  // expected header words per accepted request, checked in order
  class header_scoreboard;
    header_word_t expected_words[$];
    int errors;
    int requests;
    int rejects;
    int words_checked;

    function new();
      errors = 0;
      requests = 0;
      rejects = 0;
      words_checked = 0;
    endfunction

    // end-around carry fold down to 16 bits
    function logic [15:0] fold16(logic [31:0] acc);
      while (acc > 32'h0000_ffff)
        acc = {16'h0000, acc[15:0]} + {16'h0000, acc[31:16]};
      return acc[15:0];
    endfunction

    // folded sum of the ip header with a zero checksum field
    function logic [15:0] ip_fold(hdr_fields_t f, logic [7:0] ttl);
      logic [31:0] acc;
      acc = 32'h0;
      acc = acc + {IP_VER_IHL, IP_TOS} + IP_TOTAL_LEN + f.ip_ident + IP_FLAGS_DF
            + {ttl, PROTO_NUM_TCP} + f.src_addr[31:16] + f.src_addr[15:0]
            + f.dest_addr[31:16] + f.dest_addr[15:0];
      return fold16(acc);
    endfunction

    // folded sum of pseudo-header plus tcp header with a zero checksum field
    function logic [15:0] tcp_fold(hdr_fields_t f);
      logic [31:0] acc;
      acc = 32'h0;
      acc = acc + f.src_addr[31:16] + f.src_addr[15:0] + f.dest_addr[31:16]
            + f.dest_addr[15:0] + PROTO_NUM_TCP + TCP_LEN + f.src_port + f.dest_port
            + f.seq_number[31:16] + f.seq_number[15:0] + f.ack_number[31:16]
            + f.ack_number[15:0] + TCP_OFF_FLAGS + f.window;
      return fold16(acc);
    endfunction

    // complement, a zero checksum goes out as all ones
    function logic [15:0] csum_of(logic [15:0] folded);
      logic [15:0] r;
      r = ~folded;
      return (r == 16'h0000) ? CSUM_ZERO_SUB : r;
    endfunction

    function int pending();
      return expected_words.size();
    endfunction

    // accepted request: queue the words it must produce
    function void note_request(hdr_fields_t f, logic [1:0] v4, logic [7:0] ttl);
      logic [31:0] w [HDR_WORDS];
      header_word_t e;
      requests++;
      if (v4 != BOTH_V4) begin
        rejects++;
        e.word = 32'h0;
        e.last = 1'b1;
        e.status = STATUS_REJECT;
        expected_words.push_back(e);
        return;
      end
      w[0] = {IP_VER_IHL, IP_TOS, IP_TOTAL_LEN};
      w[1] = {f.ip_ident, IP_FLAGS_DF};
      w[2] = {ttl, PROTO_NUM_TCP, csum_of(ip_fold(f, ttl))};
      w[3] = f.src_addr;
      w[4] = f.dest_addr;
      w[5] = {f.src_port, f.dest_port};
      w[6] = f.seq_number;
      w[7] = f.ack_number;
      w[8] = {TCP_OFF_FLAGS, f.window};
      w[9] = {csum_of(tcp_fold(f)), 16'h0000};
      for (int i = 0; i < HDR_WORDS; i++) begin
        e.word = w[i];
        e.last = (i == HDR_WORDS - 1);
        e.status = STATUS_OK;
        expected_words.push_back(e);
      end
    endfunction

    // accepted output word against the oldest expectation
    function void check_word(logic [31:0] word, logic last, logic status);
      header_word_t e;
      words_checked++;
      if (expected_words.size() == 0) begin
        errors++;
        $display("%0t: unexpected word: expected none, actual word %h last %b status %b",
                 $time, word, last, status);
        return;
      end
      e = expected_words.pop_front();
      if (word !== e.word) begin
        errors++;
        $display("%0t: header word mismatch: expected %h, actual %h", $time, e.word, word);
      end
      if (last !== e.last) begin
        errors++;
        $display("%0t: tlast mismatch: expected %b, actual %b", $time, e.last, last);
      end
      if (status !== e.status) begin
        errors++;
        $display("%0t: status mismatch: expected %b, actual %b", $time, e.status, status);
      end
    endfunction
  endclass

  logic         clk;
  logic         rst;
  logic         cfg_wr_en;
  logic [7:0]   cfg_wr_data;
  logic         s_axis_tvalid;
  logic         s_axis_tready;
  // dest_addr, src_addr, dest_port, src_port, window, ack_number, seq_number,
  // ip_ident
  logic [191:0] s_axis_tdata;
  // dest_is_ipv4, src_is_ipv4
  logic [1:0]   s_axis_tuser;
  logic         m_axis_tvalid;
  logic         m_axis_tready;
  // header_word
  logic [31:0]  m_axis_tdata;
  logic         m_axis_tlast;
  // status
  logic         m_axis_tuser;

  header_scoreboard sb = new();
  logic [7:0] ttl_now;
  bit         src_idle_on;
  bit         sink_idle_on;
  int         sink_hold_left;

  ipv4_tcp_syn_header_builder dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_wr_data   (cfg_wr_data),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // run limit
  initial begin
    #1_000_000;
    $display("tb: FAIL");
    $finish;
  end

  // idle length before an item: mostly none or short, a few long
  function int pick_gap(bit idle_on);
    int r;
    if (!idle_on)
      return 0;
    r = $urandom_range(0, 99);
    if (r < 55)
      return 0;
    if (r < 90)
      return $urandom_range(1, 3);
    return $urandom_range(6, 30);
  endfunction

  // adjust ident / window so that the folded sums come out as all ones (checksum zero)
  function hdr_fields_t with_zero_sums(hdr_fields_t f, logic [7:0] ttl, bit zero_ip,
                                       bit zero_tcp);
    if (zero_ip) begin
      f.ip_ident = 16'h0000;
      f.ip_ident = 16'hffff - sb.ip_fold(f, ttl);
    end
    if (zero_tcp) begin
      f.window = 16'h0000;
      f.window = 16'hffff - sb.tcp_fold(f);
    end
    return f;
  endfunction

  function hdr_fields_t random_fields();
    hdr_fields_t f;
    f.dest_addr = $urandom;
    f.src_addr = $urandom;
    f.dest_port = 16'($urandom_range(0, 65535));
    f.src_port = 16'($urandom_range(0, 65535));
    f.window = 16'($urandom_range(0, 65535));
    f.ack_number = $urandom;
    f.seq_number = $urandom;
    f.ip_ident = 16'($urandom_range(0, 65535));
    return f;
  endfunction

  // output side: check accepted words, then pick next tready
  initial begin
    int stall_left;
    stall_left = 0;
    m_axis_tready = 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && m_axis_tvalid && m_axis_tready)
        sb.check_word(m_axis_tdata, m_axis_tlast, m_axis_tuser);
      if (sink_hold_left > 0) begin
        m_axis_tready <= 1'b0;
        sink_hold_left--;
      end else if (!sink_idle_on) begin
        m_axis_tready <= 1'b1;
      end else if (stall_left > 0) begin
        m_axis_tready <= 1'b0;
        stall_left--;
      end else if ($urandom_range(0, 99) < 25) begin
        m_axis_tready <= 1'b0;
        stall_left = ($urandom_range(0, 99) < 85) ? $urandom_range(0, 2)
                                                   : $urandom_range(9, 39);
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  // offer one request after an idle gap and wait for its handshake
  task automatic send_request(hdr_fields_t f, logic [1:0] v4, int gap);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= f;
    s_axis_tuser <= v4;
    do @(posedge clk); while (!s_axis_tready);
    sb.note_request(f, v4, ttl_now);
  endtask

  // random requests, mostly valid, some rejected, some with zero checksums
  task automatic send_random(int count);
    hdr_fields_t f;
    logic [1:0]  v4;
    int          r;
    for (int i = 0; i < count; i++) begin
      f = random_fields();
      v4 = ($urandom_range(0, 9) < 8) ? BOTH_V4 : 2'($urandom_range(0, 2));
      r = $urandom_range(0, 99);
      f = with_zero_sums(f, ttl_now, r < 5, r >= 5 && r < 10);
      send_request(f, v4, pick_gap(src_idle_on));
    end
  endtask

  // stop offering and wait until every expected word is out
  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_ttl(logic [7:0] value);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    ttl_now = value;
  endtask

  // main sequence
  initial begin
    hdr_fields_t f;
    int          ttl_settings;
    rst = 1'b1;
    cfg_wr_en = 1'b0;
    cfg_wr_data = 8'h00;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    s_axis_tuser = 2'b00;
    src_idle_on = 1'b0;
    sink_idle_on = 1'b0;
    sink_hold_left = 0;
    ttl_now = TTL_RESET;
    ttl_settings = 1;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: field extremes, rejects, zero checksums, reset ttl
    f = '0;
    send_request(f, BOTH_V4, 0);
    f = '1;
    send_request(f, BOTH_V4, 0);
    send_request(f, 2'b00, 0);
    send_request(random_fields(), 2'b01, 0);
    send_request(random_fields(), 2'b10, 0);
    f = with_zero_sums('0, ttl_now, 1'b1, 1'b0);
    send_request(f, BOTH_V4, 0);
    f = with_zero_sums('0, ttl_now, 1'b0, 1'b1);
    send_request(f, BOTH_V4, 0);
    f = with_zero_sums(random_fields(), ttl_now, 1'b1, 1'b1);
    send_request(f, BOTH_V4, 0);
    f = {6{32'h5555_5555}};
    send_request(f, BOTH_V4, 0);
    f = {6{32'haaaa_aaaa}};
    send_request(f, BOTH_V4, 0);
    f = '0;
    f.dest_port = '1;
    f.src_port = '1;
    f.window = '1;
    send_request(f, BOTH_V4, 0);
    f = '0;
    f.seq_number = '1;
    f.ack_number = '1;
    send_request(f, BOTH_V4, 0);
    send_request(random_fields(), BOTH_V4, 0);
    wait_drained();

    // ttl at its top, idles on both sides
    write_ttl(8'hff);
    ttl_settings++;
    src_idle_on = 1'b1;
    sink_idle_on = 1'b1;
    send_random(32);
    wait_drained();

    // ttl zero, no idling at all
    write_ttl(8'h00);
    ttl_settings++;
    src_idle_on = 1'b0;
    sink_idle_on = 1'b0;
    send_random(32);
    wait_drained();

    // long output hold-off while requests keep coming back to back
    write_ttl(8'($urandom_range(1, 254)));
    ttl_settings++;
    sink_hold_left = 150;
    send_random(16);
    sink_idle_on = 1'b1;
    send_random(16);
    wait_drained();

    // sender gaps only
    write_ttl(8'($urandom_range(1, 254)));
    ttl_settings++;
    src_idle_on = 1'b1;
    sink_idle_on = 1'b0;
    send_random(32);
    wait_drained();

    // back to the reset value, receiver stalls only
    write_ttl(TTL_RESET);
    ttl_settings++;
    src_idle_on = 1'b0;
    sink_idle_on = 1'b1;
    send_random(32);
    wait_drained();
    repeat (20) @(posedge clk);

    $display("tb: %0d requests (%0d rejected), %0d header words checked, %0d ttl settings",
             sb.requests, sb.rejects, sb.words_checked, ttl_settings);
    if (sb.errors == 0 && sb.pending() == 0)
      $display("tb: PASS");
    else
      $display("tb: FAIL");
    $finish;
  end

endmodule
